// ----- rtl/core/wsp_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// wsp_pkg
// Shared types and constants for the world to screen projection pipeline.
// ----------------------------------------------------------------------------
package wsp_pkg;

    localparam int COORD_W   = 32;
    localparam int PROD_W    = 64;
    localparam int FRAC_W    = 16;
    localparam int CLIP_W    = 50;
    localparam int NUM_REGS  = 8;
    localparam int IDX_W     = 3;
    localparam int REG_W     = 64;
    localparam int DIV_STEPS = 32;
    localparam int CLIP_LAT  = 3;
    localparam int DIV_LAT   = DIV_STEPS + 2;
    localparam int SCR_LAT   = 2;
    localparam int TOTAL_LAT = CLIP_LAT + DIV_LAT + SCR_LAT;

    localparam int DEF_VIEW_WIDTH  = 1920;
    localparam int DEF_VIEW_HEIGHT = 1080;

    localparam logic signed [COORD_W-1:0] ONE_Q16 = 32'sd65536;
    localparam logic signed [COORD_W-1:0] Q_MAX   = 32'sh7FFF_FFFF;
    localparam logic signed [COORD_W-1:0] Q_MIN   = 32'sh8000_0000;

    typedef logic [NUM_REGS-1:0][REG_W-1:0] t_mat;

    typedef struct packed {
        logic signed [CLIP_W-1:0] x;
        logic signed [CLIP_W-1:0] y;
        logic signed [CLIP_W-1:0] z;
        logic signed [CLIP_W-1:0] w;
    } t_clip;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } t_ndc;

    // Identity matrix; register 7 first.
    localparam t_mat MAT_RESET = {
        64'h0001_0000_0000_0000, 64'h0, 64'h0000_0000_0001_0000, 64'h0,
        64'h0, 64'h0001_0000_0000_0000, 64'h0, 64'h0000_0000_0001_0000
    };

endpackage
`default_nettype wire

// ----- rtl/core/wsp_clip.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// wsp_clip
// Matrix times point: products, floor to Q16.16, then a two level sum.
// ----------------------------------------------------------------------------
module wsp_clip (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_valid,
    input  wsp_pkg::t_mat                        i_mat,
    input  wire logic signed [wsp_pkg::COORD_W-1:0] i_x,
    input  wire logic signed [wsp_pkg::COORD_W-1:0] i_y,
    input  wire logic signed [wsp_pkg::COORD_W-1:0] i_z,
    output logic                                 o_valid,
    output wsp_pkg::t_clip                       o_clip
);
    import wsp_pkg::*;

    localparam int SUM_W = PROD_W - FRAC_W + 1;

    logic [CLIP_LAT-1:0]      r_vld;
    logic signed [CLIP_W-1:0] r_clip [4];

    genvar g;
    generate
        for (g = 0; g < 4; g++) begin : g_row
            logic signed [PROD_W-1:0]  r_p0, r_p1, r_p2;
            logic signed [COORD_W-1:0] r_c3;
            logic signed [SUM_W-1:0]   r_sa, r_sb;

            always_ff @(posedge i_clk) begin
                r_p0 <= PROD_W'($signed(i_mat[2*g][31:0]))  * PROD_W'(i_x);
                r_p1 <= PROD_W'($signed(i_mat[2*g][63:32])) * PROD_W'(i_y);
                r_p2 <= PROD_W'($signed(i_mat[2*g+1][31:0])) * PROD_W'(i_z);
                r_c3 <= $signed(i_mat[2*g+1][63:32]);
                // arithmetic shift is the floor of the Q32.32 product
                r_sa <= SUM_W'(r_p0 >>> FRAC_W) + SUM_W'(r_p1 >>> FRAC_W);
                r_sb <= SUM_W'(r_p2 >>> FRAC_W) + SUM_W'(r_c3);
                r_clip[g] <= CLIP_W'(r_sa) + CLIP_W'(r_sb);
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[CLIP_LAT-2:0], i_valid};
        end
    end

    assign o_valid  = r_vld[CLIP_LAT-1];
    assign o_clip.x = r_clip[0];
    assign o_clip.y = r_clip[1];
    assign o_clip.z = r_clip[2];
    assign o_clip.w = r_clip[3];

endmodule
`default_nettype wire

// ----- rtl/core/wsp_div.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// wsp_div
// Pipelined restoring divider: num * 65536 / den, truncated, saturated.
// ----------------------------------------------------------------------------
module wsp_div (
    input  wire                                     i_clk,
    input  wire                                     i_rst_n,
    input  wire                                     i_valid,
    input  wire logic signed [wsp_pkg::CLIP_W-1:0]  i_num,
    input  wire logic signed [wsp_pkg::CLIP_W-1:0]  i_den,
    output logic                                    o_valid,
    output logic signed [wsp_pkg::COORD_W-1:0]      o_quot
);
    import wsp_pkg::*;

    logic [CLIP_W-1:0] n_abs, d_abs;

    logic                 r_vld [DIV_STEPS+1];
    logic                 r_neg [DIV_STEPS+1];
    logic                 r_ovf [DIV_STEPS+1];
    logic [CLIP_W-1:0]    r_rem [DIV_STEPS+1];
    logic [CLIP_W-1:0]    r_den [DIV_STEPS+1];
    logic [DIV_STEPS-1:0] r_bits[DIV_STEPS+1];
    logic [DIV_STEPS-1:0] r_quo [DIV_STEPS+1];
    logic                 r_out_vld;
    logic signed [COORD_W-1:0] r_quot;

    assign n_abs = i_num[CLIP_W-1] ? (~i_num + 1'b1) : i_num;
    assign d_abs = i_den[CLIP_W-1] ? (~i_den + 1'b1) : i_den;

    // Prep: quotient of 2^16 or more saturates.
    always_ff @(posedge i_clk) begin
        r_neg[0]  <= i_num[CLIP_W-1] ^ i_den[CLIP_W-1];
        r_ovf[0]  <= (n_abs >> FRAC_W) >= d_abs;
        r_rem[0]  <= n_abs >> FRAC_W;
        r_bits[0] <= {n_abs[FRAC_W-1:0], {(DIV_STEPS-FRAC_W){1'b0}}};
        r_den[0]  <= d_abs;
        r_quo[0]  <= '0;
    end

    genvar k;
    generate
        for (k = 0; k < DIV_STEPS; k++) begin : g_step
            logic [CLIP_W:0] t_try;
            logic            ge;
            assign t_try = {r_rem[k], r_bits[k][DIV_STEPS-1]};
            assign ge    = t_try >= {1'b0, r_den[k]};
            always_ff @(posedge i_clk) begin
                r_rem[k+1]  <= ge ? CLIP_W'(t_try - {1'b0, r_den[k]}) : CLIP_W'(t_try);
                r_quo[k+1]  <= {r_quo[k][DIV_STEPS-2:0], ge};
                r_bits[k+1] <= r_bits[k] << 1;
                r_den[k+1]  <= r_den[k];
                r_neg[k+1]  <= r_neg[k];
                r_ovf[k+1]  <= r_ovf[k];
            end
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[k+1] <= 1'b0;
                end else begin
                    r_vld[k+1] <= r_vld[k];
                end
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0]  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_vld[0]  <= i_valid;
            r_out_vld <= r_vld[DIV_STEPS];
        end
    end

    // Sign and saturate.
    always_ff @(posedge i_clk) begin
        if (r_ovf[DIV_STEPS]) begin
            r_quot <= r_neg[DIV_STEPS] ? Q_MIN : Q_MAX;
        end else if (r_neg[DIV_STEPS]) begin
            r_quot <= r_quo[DIV_STEPS][DIV_STEPS-1] ? Q_MIN
                                                     : -$signed(r_quo[DIV_STEPS]);
        end else begin
            r_quot <= r_quo[DIV_STEPS][DIV_STEPS-1] ? Q_MAX
                                                     : $signed(r_quo[DIV_STEPS]);
        end
    end

    assign o_valid = r_out_vld;
    assign o_quot  = r_quot;

endmodule
`default_nettype wire

// ----- rtl/core/wsp_screen.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// wsp_screen
// Viewport mapping, in-view test and zero-w defaults.
// ----------------------------------------------------------------------------
module wsp_screen #(
    parameter int VIEW_WIDTH  = wsp_pkg::DEF_VIEW_WIDTH,
    parameter int VIEW_HEIGHT = wsp_pkg::DEF_VIEW_HEIGHT
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_valid,
    input  wire                                  i_wz,
    input  wsp_pkg::t_ndc                        i_ndc,
    output logic                                 o_valid,
    output logic signed [wsp_pkg::COORD_W-1:0]   o_screen_x,
    output logic signed [wsp_pkg::COORD_W-1:0]   o_screen_y,
    output logic signed [wsp_pkg::COORD_W-1:0]   o_depth_ndc,
    output logic                                 o_in_view,
    output logic                                 o_w_zero
);
    import wsp_pkg::*;

    localparam int OP_W = COORD_W + 2;
    localparam int WW   = $clog2(VIEW_WIDTH + 1) + 1;
    localparam int HW   = $clog2(VIEW_HEIGHT + 1) + 1;
    localparam int PXW  = OP_W + WW;
    localparam int PYW  = OP_W + HW;

    logic signed [OP_W-1:0] ox, oy;
    logic signed [PXW-1:0]  r_px, hx;
    logic signed [PYW-1:0]  r_py, hy;
    logic signed [COORD_W-1:0] r_nz;
    logic r_vis, r_wz, r_vld_a;
    logic signed [COORD_W-1:0] r_sx, r_sy, r_dz;
    logic r_iv, r_wz_o, r_vld_o;

    assign ox = OP_W'(i_ndc.x) + OP_W'(ONE_Q16);
    assign oy = OP_W'(ONE_Q16) - OP_W'(i_ndc.y);

    always_ff @(posedge i_clk) begin
        r_px  <= PXW'(ox) * PXW'(WW'(VIEW_WIDTH));
        r_py  <= PYW'(oy) * PYW'(HW'(VIEW_HEIGHT));
        r_nz  <= i_ndc.z;
        r_wz  <= i_wz;
        r_vis <= (i_ndc.x >= -ONE_Q16) && (i_ndc.x <= ONE_Q16) &&
                 (i_ndc.y >= -ONE_Q16) && (i_ndc.y <= ONE_Q16) &&
                 (i_ndc.z >= -ONE_Q16) && (i_ndc.z <= ONE_Q16);
    end

    // floor halving, then clamp to 32 bits
    assign hx = r_px >>> 1;
    assign hy = r_py >>> 1;

    always_ff @(posedge i_clk) begin
        if (r_wz) begin
            r_sx <= -ONE_Q16;
            r_sy <= -ONE_Q16;
            r_dz <= '0;
            r_iv <= 1'b1;
        end else begin
            r_sx <= (hx > PXW'(Q_MAX)) ? Q_MAX :
                    (hx < PXW'(Q_MIN)) ? Q_MIN : COORD_W'(hx);
            r_sy <= (hy > PYW'(Q_MAX)) ? Q_MAX :
                    (hy < PYW'(Q_MIN)) ? Q_MIN : COORD_W'(hy);
            r_dz <= r_nz;
            r_iv <= r_vis;
        end
        r_wz_o <= r_wz;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
            r_vld_o <= 1'b0;
        end else begin
            r_vld_a <= i_valid;
            r_vld_o <= r_vld_a;
        end
    end

    assign o_valid     = r_vld_o;
    assign o_screen_x  = r_sx;
    assign o_screen_y  = r_sy;
    assign o_depth_ndc = r_dz;
    assign o_in_view   = r_iv;
    assign o_w_zero    = r_wz_o;

endmodule
`default_nettype wire

// ----- rtl/core/world_to_screen_projection.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// world_to_screen_projection
// Projects Q16.16 world points through a 4x4 matrix to screen pixels.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: a transaction is taken at each clock where start is high
//   and busy is low. busy stays low, so a point can be issued every clock.
//   Result channel: o_valid marks one cycle holding screen x/y, ndc depth,
//   in-view and w-zero flags. Results leave in issue order and the receiver
//   must take them; nothing here can hold them off.
//   Configuration: i_cfg_we writes i_cfg_data into matrix register
//   i_cfg_idx (two Q16.16 coefficients each). Write only while idle.
// Pipeline: from accept to o_valid, the matrix products and sums, then the
//   divider (one quotient bit per stage across 32 stages plus prep and
//   saturate), then the viewport map.
// Throughput: one point per clock; the bit-per-stage divider sets the depth.
// Reset: synchronous, active low; drops all in-flight transactions and loads
//   the identity matrix.
// ----------------------------------------------------------------------------
module world_to_screen_projection #(
    parameter int VIEW_WIDTH  = wsp_pkg::DEF_VIEW_WIDTH,
    parameter int VIEW_HEIGHT = wsp_pkg::DEF_VIEW_HEIGHT
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  start,
    output logic                                 busy,
    input  wire logic signed [wsp_pkg::COORD_W-1:0] i_world_x,
    input  wire logic signed [wsp_pkg::COORD_W-1:0] i_world_y,
    input  wire logic signed [wsp_pkg::COORD_W-1:0] i_world_z,
    input  wire                                  i_cfg_we,
    input  wire [wsp_pkg::IDX_W-1:0]             i_cfg_idx,
    input  wire [wsp_pkg::REG_W-1:0]             i_cfg_data,
    output logic                                 o_valid,
    output logic signed [wsp_pkg::COORD_W-1:0]   o_screen_x,
    output logic signed [wsp_pkg::COORD_W-1:0]   o_screen_y,
    output logic signed [wsp_pkg::COORD_W-1:0]   o_depth_ndc,
    output logic                                 o_in_view,
    output logic                                 o_w_zero
);
    import wsp_pkg::*;

    t_mat  r_mat;
    logic  accept;
    logic  clip_vld;
    t_clip clip;
    logic  dx_vld, dy_vld, dz_vld;
    t_ndc  ndc;
    logic  r_wz_dly [DIV_LAT];

    // The pipeline never stalls, so a command is always taken.
    assign busy   = 1'b0;
    assign accept = start & ~busy;

    // Matrix registers; index covers exactly the register list.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mat <= MAT_RESET;
        end else if (i_cfg_we) begin
            r_mat[i_cfg_idx] <= i_cfg_data;
        end
    end

    wsp_clip u_clip (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (accept),
        .i_mat   (r_mat),
        .i_x     (i_world_x),
        .i_y     (i_world_y),
        .i_z     (i_world_z),
        .o_valid (clip_vld),
        .o_clip  (clip)
    );

    // Three dividers share clip w as the denominator.
    wsp_div u_div_x (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(clip_vld),
        .i_num(clip.x), .i_den(clip.w), .o_valid(dx_vld), .o_quot(ndc.x)
    );
    wsp_div u_div_y (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(clip_vld),
        .i_num(clip.y), .i_den(clip.w), .o_valid(dy_vld), .o_quot(ndc.y)
    );
    wsp_div u_div_z (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(clip_vld),
        .i_num(clip.z), .i_den(clip.w), .o_valid(dz_vld), .o_quot(ndc.z)
    );

    // Carry the zero-w flag alongside the divider stages.
    always_ff @(posedge i_clk) begin
        r_wz_dly[0] <= (clip.w == '0);
        for (int i = 1; i < DIV_LAT; i++) begin
            r_wz_dly[i] <= r_wz_dly[i-1];
        end
    end

    wsp_screen #(
        .VIEW_WIDTH  (VIEW_WIDTH),
        .VIEW_HEIGHT (VIEW_HEIGHT)
    ) u_screen (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (dx_vld & dy_vld & dz_vld),
        .i_wz        (r_wz_dly[DIV_LAT-1]),
        .i_ndc       (ndc),
        .o_valid     (o_valid),
        .o_screen_x  (o_screen_x),
        .o_screen_y  (o_screen_y),
        .o_depth_ndc (o_depth_ndc),
        .o_in_view   (o_in_view),
        .o_w_zero    (o_w_zero)
    );

`ifndef SYNTH
    a_div_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (dx_vld == dy_vld) && (dx_vld == dz_vld))
        else $error("dividers out of step");

    a_wz_default: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_w_zero) |-> (o_in_view && o_screen_x == -ONE_Q16 &&
                                   o_screen_y == -ONE_Q16 && o_depth_ndc == '0))
        else $error("zero w result not defaulted");

    a_view_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_in_view && !o_w_zero) |->
            (o_depth_ndc >= -ONE_Q16 && o_depth_ndc <= ONE_Q16))
        else $error("in-view point with depth outside range");
`endif

endmodule
`default_nettype wire

// ----- verif/world_to_screen_projection_tb.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// world_to_screen_projection_tb
// Self-checking bench for the projection unit. A directed table runs first:
// extreme points, the zero-w default, tiny w, and quotient saturation. Random
// phases follow, each with a new matrix and a sender gap of 22%, 46% or none.
// Each result is compared field by field with its typed row or a predictor.
// ----------------------------------------------------------------------------
module world_to_screen_projection_tb;
    import wsp_pkg::*;

    localparam int  WATCHDOG_LIMIT = 4000;
    localparam int  PTS_PER_PHASE  = 60;
    localparam int  NUM_PHASES     = 9;
    localparam int  NUM_ROWS       = 18;
    localparam logic [IDX_W-1:0] IDX_ROW3_COLS01 = 3'd6;
    localparam logic [IDX_W-1:0] IDX_ROW3_COLS23 = 3'd7;

    typedef enum logic {ROW_CFG, ROW_PT} t_row_kind;

    typedef struct {
        logic signed [COORD_W-1:0] sx;
        logic signed [COORD_W-1:0] sy;
        logic signed [COORD_W-1:0] dz;
        logic                      vis;
        logic                      wz;
    } t_proj;

    typedef struct {
        t_row_kind                 kind;
        logic [IDX_W-1:0]          idx;
        logic [REG_W-1:0]          data;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic                      typed;
        t_proj                     res;
    } t_row;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      start;
    logic                      busy;
    logic signed [COORD_W-1:0] i_world_x;
    logic signed [COORD_W-1:0] i_world_y;
    logic signed [COORD_W-1:0] i_world_z;
    logic                      i_cfg_we;
    logic [IDX_W-1:0]          i_cfg_idx;
    logic [REG_W-1:0]          i_cfg_data;
    logic                      o_valid;
    logic signed [COORD_W-1:0] o_screen_x;
    logic signed [COORD_W-1:0] o_screen_y;
    logic signed [COORD_W-1:0] o_depth_ndc;
    logic                      o_in_view;
    logic                      o_w_zero;

    // Predictor copy of the matrix registers and the pending screen results.
    logic [REG_W-1:0] mat_shadow [NUM_REGS];
    t_proj            pending_q  [$];
    int               err_cnt;
    int               stall_cnt;
    int               gap_pct;
    t_row             dir_tab    [NUM_ROWS];

    world_to_screen_projection u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_world_x  (i_world_x),
        .i_world_y  (i_world_y),
        .i_world_z  (i_world_z),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_valid    (o_valid),
        .o_screen_x (o_screen_x),
        .o_screen_y (o_screen_y),
        .o_depth_ndc(o_depth_ndc),
        .o_in_view  (o_in_view),
        .o_w_zero   (o_w_zero)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // ---------------------------------------------------------------- predictor
    function automatic longint coef_of(int row, int col);
        logic [REG_W-1:0] r;
        r = mat_shadow[row*2 + col/2];
        if (col % 2)
            return longint'(signed'(r[63:32]));
        return longint'(signed'(r[31:0]));
    endfunction

    // Products are floored to Q16.16; the col3 term is added as is.
    function automatic longint clip_of(int row, longint x, longint y, longint z);
        return ((coef_of(row, 0) * x) >>> FRAC_W) + ((coef_of(row, 1) * y) >>> FRAC_W)
             + ((coef_of(row, 2) * z) >>> FRAC_W) + coef_of(row, 3);
    endfunction

    function automatic longint sat_q(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    // num * 65536 / den, truncated toward zero, saturated to 32 bits.
    function automatic longint ndc_quot(longint num, longint den);
        logic            neg;
        longint unsigned n, d, q, rem, m;
        neg = (num < 0) != (den < 0);
        n   = (num < 0) ? longint'(-num) : num;
        d   = (den < 0) ? longint'(-den) : den;
        q   = n / d;
        rem = n % d;
        if (q >= 64'h10000)
            return neg ? -64'sd2147483648 : 64'sd2147483647;
        m = q;
        for (int i = 0; i < FRAC_W; i++) begin
            rem = rem << 1;
            m   = m << 1;
            if (rem >= d) begin
                rem = rem - d;
                m   = m | 64'd1;
            end
        end
        if (neg)
            return (m >= 64'h8000_0000) ? -64'sd2147483648 : -longint'(m);
        return (m > 64'h7FFF_FFFF) ? 64'sd2147483647 : longint'(m);
    endfunction

    function automatic t_proj project_point(logic signed [COORD_W-1:0] x,
                                            logic signed [COORD_W-1:0] y,
                                            logic signed [COORD_W-1:0] z);
        t_proj  p;
        longint cx, cy, cz, cw, nx, ny, nz, one;
        one = longint'(ONE_Q16);
        cx  = clip_of(0, x, y, z);
        cy  = clip_of(1, x, y, z);
        cz  = clip_of(2, x, y, z);
        cw  = clip_of(3, x, y, z);
        if (cw == 0) begin
            p.sx  = -ONE_Q16;
            p.sy  = -ONE_Q16;
            p.dz  = '0;
            p.vis = 1'b1;
            p.wz  = 1'b1;
        end else begin
            nx    = ndc_quot(cx, cw);
            ny    = ndc_quot(cy, cw);
            nz    = ndc_quot(cz, cw);
            p.sx  = COORD_W'(sat_q(((nx + one) * DEF_VIEW_WIDTH) >>> 1));
            p.sy  = COORD_W'(sat_q(((one - ny) * DEF_VIEW_HEIGHT) >>> 1));
            p.dz  = COORD_W'(nz);
            p.vis = nx >= -one && nx <= one && ny >= -one && ny <= one
                 && nz >= -one && nz <= one;
            p.wz  = 1'b0;
        end
        return p;
    endfunction

    // ---------------------------------------------------------------- checker
    always @(posedge i_clk) begin
        t_proj e;
        if (i_rst_n && o_valid) begin
            if (pending_q.size() == 0) begin
                $error("unexpected result transaction, screen_x %0d", o_screen_x);
                err_cnt++;
            end else begin
                e = pending_q.pop_front();
                if (o_screen_x !== e.sx) begin
                    $error("screen_x exp %0d got %0d", e.sx, o_screen_x);
                    err_cnt++;
                end
                if (o_screen_y !== e.sy) begin
                    $error("screen_y exp %0d got %0d", e.sy, o_screen_y);
                    err_cnt++;
                end
                if (o_depth_ndc !== e.dz) begin
                    $error("depth_ndc exp %0d got %0d", e.dz, o_depth_ndc);
                    err_cnt++;
                end
                if (o_in_view !== e.vis) begin
                    $error("in_view exp %0b got %0b", e.vis, o_in_view);
                    err_cnt++;
                end
                if (o_w_zero !== e.wz) begin
                    $error("w_zero exp %0b got %0b", e.wz, o_w_zero);
                    err_cnt++;
                end
            end
        end
    end

    // Watchdog: count cycles with no transaction on either side.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            stall_cnt <= 0;
        end else begin
            stall_cnt <= stall_cnt + 1;
            if (stall_cnt >= WATCHDOG_LIMIT) begin
                $display("world_to_screen_projection_tb: done, errors");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------- stimulus
    // Hold the point until the block takes it, then log the expected result.
    task automatic issue_point(logic signed [COORD_W-1:0] x,
                               logic signed [COORD_W-1:0] y,
                               logic signed [COORD_W-1:0] z,
                               logic typed, t_proj res);
        t_proj exp_res;
        i_cfg_we <= 1'b0;
        while (gap_pct > 0 && $urandom_range(99, 0) < gap_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start     <= 1'b1;
        i_world_x <= x;
        i_world_y <= y;
        i_world_z <= z;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        exp_res   = typed ? res : project_point(x, y, z);
        pending_q = {pending_q, exp_res};
    endtask

    // Drain the pipeline, then let it settle before touching the matrix.
    task automatic drain_all();
        start    <= 1'b0;
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        while (pending_q.size() != 0)
            @(posedge i_clk);
        repeat (TOTAL_LAT + 4) @(posedge i_clk);
    endtask

    // Hold the write for one edge; the next stimulus step drops the enable.
    task automatic write_reg(logic [IDX_W-1:0] idx, logic [REG_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        mat_shadow[idx] = data;
    endtask

    function automatic logic [31:0] rand_coef(int sel);
        if (sel == 0)
            return $urandom();
        return 32'($urandom_range(131072, 0)) - 32'd65536;
    endfunction

    function automatic logic [31:0] rand_coord();
        if ($urandom_range(3, 0) == 0)
            return $urandom();
        return 32'($urandom_range(262144, 0)) - 32'd131072;
    endfunction

    initial begin
        t_proj none;
        none = '{sx: '0, sy: '0, dz: '0, vis: 1'b0, wz: 1'b0};
        // kind, idx, data, x, y, z, typed, expected
        dir_tab = '{
            '{ROW_PT, 3'd0, 64'h0, 32'sh0, 32'sh0, 32'sh0, 1'b1,
              '{62914560, 35389440, 0, 1'b1, 1'b0}},
            '{ROW_PT, 3'd0, 64'h0, 32'sh10000, 32'sh10000, 32'sh10000, 1'b1,
              '{125829120, 0, 65536, 1'b1, 1'b0}},
            '{ROW_PT, 3'd0, 64'h0, -32'sh10000, -32'sh10000, -32'sh10000, 1'b1,
              '{0, 70778880, -65536, 1'b1, 1'b0}},
            '{ROW_PT, 3'd0, 64'h0, Q_MAX, Q_MAX, Q_MAX, 1'b1,
              '{Q_MAX, Q_MIN, Q_MAX, 1'b0, 1'b0}},
            '{ROW_PT, 3'd0, 64'h0, Q_MIN, Q_MIN, Q_MIN, 1'b1,
              '{Q_MIN, Q_MAX, Q_MIN, 1'b0, 1'b0}},
            '{ROW_PT, 3'd0, 64'h0, 32'sh8000, -32'sh4000, 32'sh1234, 1'b0, none},
            // Clear the w row: every point hits the zero-w default.
            '{ROW_CFG, IDX_ROW3_COLS23, 64'h0, '0, '0, '0, 1'b0, none},
            '{ROW_PT, 3'd0, 64'h0, 32'sh50000, 32'sh7, Q_MIN, 1'b1,
              '{-65536, -65536, 0, 1'b1, 1'b1}},
            // w follows world x: zero, tiny and negative w.
            '{ROW_CFG, IDX_ROW3_COLS01, 64'h0000_0000_0001_0000, '0, '0, '0, 1'b0, none},
            '{ROW_PT, 3'd0, 64'h0, 32'sh0, Q_MAX, Q_MIN, 1'b1,
              '{-65536, -65536, 0, 1'b1, 1'b1}},
            '{ROW_PT, 3'd0, 64'h0, 32'sh1, 32'sh10000, -32'sh10000, 1'b0, none},
            '{ROW_PT, 3'd0, 64'h0, -32'sh1, 32'sh10000, 32'sh10000, 1'b0, none},
            '{ROW_PT, 3'd0, 64'h0, 32'sh20000, 32'sh20000, -32'sh20000, 1'b0, none},
            '{ROW_PT, 3'd0, 64'h0, -32'sh30000, 32'sh18000, 32'sh5, 1'b0, none},
            '{ROW_PT, 3'd0, 64'h0, Q_MAX, Q_MIN, 32'sh0, 1'b0, none},
            // Most negative z and constant coefficients in the w row.
            '{ROW_CFG, IDX_ROW3_COLS23, 64'h8000_0000_8000_0000, '0, '0, '0, 1'b0, none},
            '{ROW_PT, 3'd0, 64'h0, Q_MIN, Q_MAX, Q_MIN, 1'b0, none},
            '{ROW_PT, 3'd0, 64'h0, 32'sh10000, -32'sh1, 32'sh7FFF, 1'b0, none}
        };

        err_cnt    = 0;
        gap_pct    = 0;
        i_rst_n    <= 1'b0;
        start      <= 1'b0;
        i_world_x  <= '0;
        i_world_y  <= '0;
        i_world_z  <= '0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= '0;
        i_cfg_data <= '0;
        for (int i = 0; i < NUM_REGS; i++)
            mat_shadow[i] = MAT_RESET[i];
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table; each matrix write waits for a fully drained pipe.
        foreach (dir_tab[r]) begin
            if (dir_tab[r].kind == ROW_CFG) begin
                drain_all();
                write_reg(dir_tab[r].idx, dir_tab[r].data);
            end else begin
                issue_point(dir_tab[r].x, dir_tab[r].y, dir_tab[r].z,
                            dir_tab[r].typed, dir_tab[r].res);
            end
        end

        // Random phases: sender gaps 22%, then 46%, then none.
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            drain_all();
            gap_pct = (ph < 3) ? 22 : (ph < 6) ? 46 : 0;
            for (int i = 0; i < NUM_REGS; i++) begin
                if (ph == 0)
                    write_reg(IDX_W'(i), '1);
                else if (ph == 1)
                    write_reg(IDX_W'(i), 64'h8000_0000_8000_0000);
                else
                    write_reg(IDX_W'(i), {rand_coef($urandom_range(4, 0)),
                                          rand_coef($urandom_range(4, 0))});
            end
            // Keep w well away from zero on most random matrices.
            if (ph > 1 && $urandom_range(2, 0) != 0)
                write_reg(IDX_ROW3_COLS23,
                          {32'($urandom_range(32'h40000, 32'h8000)),
                           mat_shadow[IDX_ROW3_COLS23][31:0]});
            for (int n = 0; n < PTS_PER_PHASE; n++)
                issue_point(rand_coord(), rand_coord(), rand_coord(), 1'b0, none);
        end

        drain_all();
        if (err_cnt == 0)
            $display("world_to_screen_projection_tb: done, clean");
        else
            $display("world_to_screen_projection_tb: done, errors");
        $finish;
    end

endmodule
`default_nettype wire

// ----- sim.f -----
rtl/core/wsp_pkg.sv
rtl/core/wsp_clip.sv
rtl/core/wsp_div.sv
rtl/core/wsp_screen.sv
rtl/core/world_to_screen_projection.sv
verif/world_to_screen_projection_tb.sv
